// ----- design/address_toggle_set_macros.svh -----
// Assertion macros used by the address toggle set checker
`ifndef ADDRESS_TOGGLE_SET_MACROS_SVH
`define ADDRESS_TOGGLE_SET_MACROS_SVH

// Check a property on every clock edge outside reset
`define ATS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition is followed by another in the next cycle
`define ATS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/ats_pkg.sv -----
// Types and constants of the address toggle set
`default_nettype none

package ats_pkg;

  localparam int unsigned ATS_CAPACITY = 16;

  localparam int unsigned ADDR_W   = 48;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned COUNT_W  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_TOGGLE,
    OP_REMOVE,
    OP_FIND,
    OP_READ
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED,
    ST_REMOVED,
    ST_FOUND,
    ST_NOT_FOUND,
    ST_FULL,
    ST_READ_OK,
    ST_BAD_INDEX
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_FETCH
  } state_t;

endpackage

`default_nettype wire

// ----- design/address_toggle_set.sv -----
// Address toggle set: unordered table of device addresses with a live count
//
// Raise start for one cycle while busy is low; the transaction is taken at
// that edge. Exactly one result follows, shown for one cycle with out_valid
// high; the receiver cannot stall it. All entries sit in one table memory
// with a single read port, scanned one slot per cycle until a hit or the
// last live entry: a read fetches only the indexed slot, a removal also
// fetches the last entry to fill the hole, and an operation on an empty
// table or a read with a bad index reports without reading the memory.
// busy is high from the cycle after accept until the cycle before the
// result appears, and stays low for an operation that reports at once;
// a new transaction may start alongside the result.
// The table needs no clearing after reset.
`default_nettype none

module address_toggle_set
  import ats_pkg::*;
#(
  parameter int unsigned CAPACITY = ATS_CAPACITY
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [OP_W-1:0]     in_operation,
  input  wire logic [ADDR_W-1:0]   in_address,
  input  wire logic [IDX_W-1:0]    in_index,
  output logic                     out_valid,
  output logic [STATUS_W-1:0]      out_status,
  output logic [POS_W-1:0]         out_position,
  output logic [ADDR_W-1:0]        out_entry_out,
  output logic [COUNT_W-1:0]       out_count
);

  localparam int unsigned SW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (CW > IDX_W) ? CW : IDX_W;

  logic [ADDR_W-1:0] mem [CAPACITY];
  logic [ADDR_W-1:0] rd_data_r;

  state_t            state_r, state_nxt;
  op_t               op_r, op_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [SW-1:0]     scan_r, scan_nxt;
  logic [CW-1:0]     count_r, count_nxt;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [POS_W-1:0]    out_position_r;
  logic [ADDR_W-1:0]   out_entry_r;
  logic [COUNT_W-1:0]  out_count_r;

  logic              rd_en;
  logic [SW-1:0]     rd_addr;
  logic              wr_en;
  logic [SW-1:0]     wr_addr;
  logic [ADDR_W-1:0] wr_data;

  logic              fin;
  status_t           fin_status;
  logic [SW-1:0]     fin_pos;
  logic [ADDR_W-1:0] fin_entry;

  op_t       in_op;
  logic      hit;
  logic      more;
  logic      idx_ok;
  logic [CW-1:0] scan_inc;

  assign in_op    = op_t'(in_operation);
  assign hit      = (rd_data_r == addr_r);
  assign scan_inc = CW'(scan_r) + CW'(1);
  assign more     = (scan_inc < count_r);
  assign idx_ok   = (CMPW'(in_index) < CMPW'(count_r));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_op == OP_READ) begin
            state_nxt = idx_ok ? S_FETCH : S_IDLE;
          end else begin
            state_nxt = (count_r == '0) ? S_IDLE : S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_nxt = (op_r == OP_FIND) ? S_IDLE : S_LAST;
        end else if (more) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_LAST:  state_nxt = S_IDLE;
      S_FETCH: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Memory control, datapath and result
  always_comb begin
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = '0;
    wr_data    = addr_r;
    fin        = 1'b0;
    fin_status = ST_NOT_FOUND;
    fin_pos    = '0;
    fin_entry  = '0;
    op_nxt     = op_r;
    addr_nxt   = addr_r;
    scan_nxt   = scan_r;
    count_nxt  = count_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt   = in_op;
          addr_nxt = in_address;
          if (in_op == OP_READ) begin
            if (idx_ok) begin
              rd_en    = 1'b1;
              rd_addr  = SW'(in_index);
              scan_nxt = SW'(in_index);
            end else begin
              fin        = 1'b1;
              fin_status = ST_BAD_INDEX;
            end
          end else if (count_r == '0) begin
            // Empty table: nothing to search
            fin = 1'b1;
            if (in_op == OP_TOGGLE) begin
              wr_en      = 1'b1;
              wr_data    = in_address;
              count_nxt  = CW'(1);
              fin_status = ST_ADDED;
            end
          end else begin
            rd_en    = 1'b1;
            scan_nxt = '0;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          if (op_r == OP_FIND) begin
            fin        = 1'b1;
            fin_status = ST_FOUND;
            fin_pos    = scan_r;
          end else begin
            // Fetch the last live entry to fill the hole
            rd_en   = 1'b1;
            rd_addr = SW'(count_r - CW'(1));
          end
        end else if (more) begin
          rd_en    = 1'b1;
          rd_addr  = SW'(scan_inc);
          scan_nxt = SW'(scan_inc);
        end else begin
          fin = 1'b1;
          if (op_r == OP_TOGGLE) begin
            if (count_r < CW'(CAPACITY)) begin
              wr_en      = 1'b1;
              wr_addr    = SW'(count_r);
              count_nxt  = count_r + CW'(1);
              fin_status = ST_ADDED;
              fin_pos    = SW'(count_r);
            end else begin
              fin_status = ST_FULL;
            end
          end
        end
      end
      S_LAST: begin
        wr_en      = 1'b1;
        wr_addr    = scan_r;
        wr_data    = rd_data_r;
        count_nxt  = count_r - CW'(1);
        fin        = 1'b1;
        fin_status = ST_REMOVED;
        fin_pos    = scan_r;
      end
      S_FETCH: begin
        fin        = 1'b1;
        fin_status = ST_READ_OK;
        fin_pos    = scan_r;
        fin_entry  = rd_data_r;
      end
      default: begin
        fin = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= fin;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    addr_r <= addr_nxt;
    scan_r <= scan_nxt;
    if (fin) begin
      out_status_r   <= fin_status;
      out_position_r <= POS_W'(fin_pos);
      out_entry_r    <= fin_entry;
      out_count_r    <= COUNT_W'(count_nxt);
    end
  end

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_position  = out_position_r;
  assign out_entry_out = out_entry_r;
  assign out_count     = out_count_r;

endmodule

`default_nettype wire

// ----- design/ats_checker.sv -----
// Port-level checks of the address toggle set and their binding
`default_nettype none
`include "address_toggle_set_macros.svh"

module ats_checker
  import ats_pkg::*;
#(
  parameter int unsigned CAPACITY = ATS_CAPACITY
) (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                start,
  input wire logic                busy,
  input wire logic                out_valid,
  input wire logic [STATUS_W-1:0] out_status,
  input wire logic [ADDR_W-1:0]   out_entry_out,
  input wire logic [COUNT_W-1:0]  out_count
);

  // The block is free again by the time a result is shown
  `ATS_ASSERT(a_idle_on_result, out_valid |-> !busy, "busy high while result shown")

  // A taken transaction either works on or reports at once
  `ATS_ASSERT_NEXT(a_accept_progress, start && !busy, busy || out_valid, "transaction lost")

  // Only a read reports an entry
  `ATS_ASSERT(a_entry_zero, (out_valid && out_status != ST_READ_OK) |-> (out_entry_out == '0), "entry on non-read")

  // Count never exceeds the table size
  `ATS_ASSERT(a_count_bound, out_valid |-> (CAPACITY >= 32 || out_count <= COUNT_W'(CAPACITY)), "count beyond capacity")

endmodule

bind address_toggle_set ats_checker #(.CAPACITY(CAPACITY)) u_ats_checker (.*);

`default_nettype wire

// ----- sim/tb.sv -----
// Testbench for address_toggle_set: directed and random transactions with result checking
`timescale 1ns / 100ps

module tb;
  import ats_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 1120;
  localparam int POOL_SIZE    = 32;

  typedef struct packed {
    status_t             status;
    logic [POS_W-1:0]    position;
    logic [ADDR_W-1:0]   entry;
    logic [COUNT_W-1:0]  count;
  } set_result_t;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  op_t                 in_operation = OP_TOGGLE;
  logic [ADDR_W-1:0]   in_address = '0;
  logic [IDX_W-1:0]    in_index = '0;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [POS_W-1:0]    out_position;
  logic [ADDR_W-1:0]   out_entry_out;
  logic [COUNT_W-1:0]  out_count;

  // shadow copy of the set, updated when each transaction is accepted
  logic [ADDR_W-1:0]   set_table [ATS_CAPACITY];
  int                  set_count = 0;
  set_result_t         expected_results [$];

  int cycle_count = 0;
  int mismatches = 0;
  int items_sent = 0;
  int results_checked = 0;
  int status_hits [7];
  int burst_left = 0;

  address_toggle_set dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_operation  (in_operation),
    .in_address    (in_address),
    .in_index      (in_index),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_position  (out_position),
    .out_entry_out (out_entry_out),
    .out_count     (out_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int slot_of(logic [ADDR_W-1:0] addr);
    for (int i = 0; i < set_count; i++) begin
      if (set_table[i] == addr) return i;
    end
    return -1;
  endfunction

  function automatic set_result_t apply_op(op_t op, logic [ADDR_W-1:0] addr,
                                           logic [IDX_W-1:0] idx);
    set_result_t r;
    int slot;
    r.status   = ST_NOT_FOUND;
    r.position = '0;
    r.entry    = '0;
    slot = slot_of(addr);
    case (op)
      OP_TOGGLE, OP_REMOVE: begin
        if (slot >= 0) begin
          // swap the last live entry into the freed slot
          set_table[slot] = set_table[set_count-1];
          set_count--;
          r.status   = ST_REMOVED;
          r.position = slot[POS_W-1:0];
        end else if (op == OP_TOGGLE) begin
          if (set_count < ATS_CAPACITY) begin
            r.position = set_count[POS_W-1:0];
            set_table[set_count] = addr;
            set_count++;
            r.status = ST_ADDED;
          end else begin
            r.status = ST_FULL;
          end
        end
      end
      OP_FIND: begin
        if (slot >= 0) begin
          r.status   = ST_FOUND;
          r.position = slot[POS_W-1:0];
        end
      end
      default: begin
        if (int'(idx) < set_count) begin
          r.status   = ST_READ_OK;
          r.position = idx;
          r.entry    = set_table[idx];
        end else begin
          r.status = ST_BAD_INDEX;
        end
      end
    endcase
    r.count = set_count[COUNT_W-1:0];
    return r;
  endfunction

  // hold start until the block takes the transaction, then record its outcome
  task automatic send_op(op_t op, logic [ADDR_W-1:0] addr, logic [IDX_W-1:0] idx);
    in_operation <= op;
    in_address   <= addr;
    in_index     <= idx;
    start        <= 1'b1;
    do @(posedge clk); while (busy);
    expected_results.push_back(apply_op(op, addr, idx));
    items_sent++;
  endtask

  // send in bursts; long bursts give stretches with no gaps at all
  task automatic issue(op_t op, logic [ADDR_W-1:0] addr, logic [IDX_W-1:0] idx);
    send_op(op, addr, idx);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(0, 8);
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  function automatic logic [ADDR_W-1:0] rand_addr();
    return ADDR_W'({$urandom, $urandom});
  endfunction

  task automatic flag_field(string field, logic [ADDR_W-1:0] exp_val,
                            logic [ADDR_W-1:0] got_val);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s at cycle %0d: expected %0h, got %0h", field, cycle_count,
               exp_val, got_val);
  endtask

  always @(posedge clk) begin
    set_result_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        flag_field("unexpected result, status", '0, out_status);
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        status_hits[want.status]++;
        if (out_status !== want.status) flag_field("status", want.status, out_status);
        if (out_position !== want.position) flag_field("position", want.position, out_position);
        if (out_entry_out !== want.entry) flag_field("entry_out", want.entry, out_entry_out);
        if (out_count !== want.count) flag_field("count", want.count, out_count);
      end
    end
  end

  task automatic test_empty_table();
    issue(OP_READ, '0, 4'd0);
    issue(OP_READ, '1, 4'd15);
    issue(OP_FIND, '1, 4'd0);
    issue(OP_REMOVE, '0, 4'd7);
    issue(OP_TOGGLE, '1, 4'd0);
    issue(OP_TOGGLE, '1, 4'd0);
  endtask

  task automatic test_toggle_swap();
    issue(OP_TOGGLE, 48'hFFFF_FFFF_FFFF, 4'd0);
    issue(OP_TOGGLE, 48'h0000_0000_0000, 4'd0);
    issue(OP_TOGGLE, 48'h8000_0000_0001, 4'd0);
    issue(OP_FIND, 48'h0000_0000_0000, 4'd0);
    issue(OP_FIND, 48'h0000_0000_0001, 4'd0);
    issue(OP_READ, '0, 4'd2);
    issue(OP_TOGGLE, 48'hFFFF_FFFF_FFFF, 4'd0);
    issue(OP_READ, '0, 4'd0);
    // last live entry removed: it is copied onto itself
    issue(OP_REMOVE, 48'h0000_0000_0000, 4'd0);
    issue(OP_REMOVE, 48'h8000_0000_0001, 4'd0);
  endtask

  task automatic test_capacity();
    for (int i = 0; i < ATS_CAPACITY; i++)
      issue(OP_TOGGLE, {8'hA5, 8'(i), 32'h5A5A_0000 | 32'(i)}, 4'(i));
    issue(OP_TOGGLE, 48'h1234_5678_9ABC, 4'd0);
    issue(OP_READ, '0, 4'd15);
    issue(OP_REMOVE, {8'hA5, 8'd0, 32'h5A5A_0000}, 4'd0);
    issue(OP_TOGGLE, 48'h1234_5678_9ABC, 4'd0);
  endtask

  task automatic test_random();
    logic [ADDR_W-1:0] pool [POOL_SIZE];
    logic [ADDR_W-1:0] addr;
    op_t               op;
    int                pick;
    bit                grow;
    // half the pool are near matches that differ from another entry in one bit
    for (int i = 0; i < POOL_SIZE / 2; i++) pool[i] = rand_addr();
    for (int i = POOL_SIZE / 2; i < POOL_SIZE; i++)
      pool[i] = pool[i - POOL_SIZE / 2] ^ (48'd1 << $urandom_range(0, ADDR_W - 1));
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // alternate between filling and draining the table
      grow = ((n / 64) % 2) == 0;
      pick = $urandom_range(0, 99);
      if (pick < 50) op = OP_TOGGLE;
      else if (pick < 65) op = OP_REMOVE;
      else if (pick < 80) op = OP_FIND;
      else op = OP_READ;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        addr = rand_addr();
      end else if (set_count > 0 && (op == OP_TOGGLE ? !grow == (pick < 85) : pick < 70)) begin
        addr = set_table[$urandom_range(0, set_count - 1)];
      end else begin
        addr = pool[$urandom_range(0, POOL_SIZE - 1)];
      end
      issue(op, addr, 4'($urandom_range(0, 15)));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_table();
    test_toggle_swap();
    test_capacity();
    test_random();
    if (start) start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("sent %0d transactions, checked %0d results, %0d mismatches",
             items_sent, results_checked, mismatches);
    $display("statuses: added %0d removed %0d found %0d not found %0d full %0d read %0d bad %0d",
             status_hits[ST_ADDED], status_hits[ST_REMOVED], status_hits[ST_FOUND],
             status_hits[ST_NOT_FOUND], status_hits[ST_FULL], status_hits[ST_READ_OK],
             status_hits[ST_BAD_INDEX]);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
